/* src/nrt_pkg.sv */
// nrt_pkg: shared types and codes of the rendezvous table
// used by nrt_front, nrt_back and nat_rendezvous_table_core
`default_nettype none
package nrt_pkg;
    localparam int NRT_TABLE_ENTRIES = 64;

    // command codes of the input channel
    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_QUERY    = 3'd2;
    localparam logic [2:0] CMD_LEAVE    = 3'd3;

    // reply kinds of the output channel
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_INFO   = 2'd1;
    localparam logic [1:0] KIND_NOTICE = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    typedef enum logic [1:0] {
        OP_REG,
        OP_QUERY,
        OP_LEAVE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] own_sid;
        logic [15:0] peer_sid;
        logic [31:0] sender_ip;
        logic [15:0] sender_port;
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [15:0] fwd_port;
        logic [31:0] peer_ip_in;
        logic [15:0] peer_port_in;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [15:0] sid;
        logic [31:0] mapped_ip;
        logic [15:0] mapped_port;
        logic [31:0] lan_ip;
        logic [15:0] lan_port;
        logic [15:0] fwd_port;
    } t_entry;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [15:0] own_sid;
        logic [15:0] peer_sid;
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [15:0] fwd_port;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic        last;
    } t_result;
endpackage
`default_nettype wire

/* src/nrt_front.sv */
// nrt_front: accepts packets, drops commands without effect, queues the rest
// depends on nrt_pkg
`default_nettype none
module nrt_front
    import nrt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_hold,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_command,
    input  wire  [15:0] i_own_sid,
    input  wire  [15:0] i_peer_sid,
    input  wire  [31:0] i_sender_ip,
    input  wire  [15:0] i_sender_port,
    input  wire  [31:0] i_local_ip,
    input  wire  [15:0] i_local_port,
    input  wire  [15:0] i_fwd_port,
    input  wire  [31:0] i_peer_ip_in,
    input  wire  [15:0] i_peer_port_in,
    output logic        o_item_valid,
    output t_item       o_item,
    input  wire         i_item_ready
);
    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_item       n_item;
    logic        keep, push, pop;

    // classify the command
    always_comb begin
        keep   = 1'b1;
        n_item = '{op: OP_REG, own_sid: i_own_sid, peer_sid: i_peer_sid,
                   sender_ip: i_sender_ip, sender_port: i_sender_port,
                   local_ip: i_local_ip, local_port: i_local_port,
                   fwd_port: i_fwd_port, peer_ip_in: i_peer_ip_in,
                   peer_port_in: i_peer_port_in};
        case (i_command)
            CMD_REGISTER: n_item.op = OP_REG;
            CMD_QUERY:    n_item.op = OP_QUERY;
            CMD_LEAVE:    n_item.op = OP_LEAVE;
            default:      keep = 1'b0;
        endcase
    end

    assign o_ready      = (r_cnt != 2'd2) && !i_hold;
    assign push         = i_valid && o_ready && keep;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign pop          = o_item_valid && i_item_ready;

    // two-entry queue toward the table engine
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* src/nrt_back.sv */
// nrt_back: table engine, scans the entry memory and builds reply packets
// depends on nrt_pkg
`default_nettype none
module nrt_back
    import nrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = NRT_TABLE_ENTRIES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    output logic        o_init,
    input  wire         i_item_valid,
    input  t_item       i_item,
    output logic        o_item_ready,
    output logic        o_valid,
    input  wire         i_ready,
    output t_result     o_result
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_DECIDE, ST_NOTICE
    } t_state;

    t_entry  mem [TABLE_ENTRIES];
    t_entry  r_rd;
    logic [IW-1:0] r_rd_idx;
    logic    r_rd_vld, r_rd_last;

    t_state  r_state;
    logic [IW-1:0] r_idx;
    logic    r_issuing;
    t_item   r_item;
    logic    r_own_hit, r_peer_hit, r_free_hit;
    logic [IW-1:0] r_own_idx, r_free_idx;
    t_entry  r_own, r_peer;
    logic    r_o_valid;
    t_result r_o;

    logic    out_free, same, mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry  mem_wdata;
    logic [15:0] f_port;
    logic [31:0] a_ip, n_ip;
    logic [15:0] a_port, n_port;
    t_result echo, info, notice;

    assign out_free     = !r_o_valid || i_ready;
    assign o_valid      = r_o_valid;
    assign o_result     = r_o;
    assign o_init       = (r_state == ST_CLEAR);
    assign o_item_ready = (r_state == ST_IDLE);

    // reply contents from the scan results
    always_comb begin
        same   = (r_peer.mapped_ip == r_item.sender_ip);
        f_port = same ? r_item.fwd_port : r_peer.fwd_port;
        a_ip   = same ? r_peer.lan_ip : r_peer.mapped_ip;
        a_port = same ? r_peer.lan_port : r_peer.mapped_port;
        if (same) begin
            n_ip   = r_own_hit ? r_own.lan_ip : a_ip;
            n_port = r_own_hit ? r_own.lan_port : a_port;
        end else begin
            n_ip   = r_item.sender_ip;
            n_port = r_item.sender_port;
        end
        echo = '{reply_kind: (r_own_hit || r_free_hit) ? KIND_ACK : KIND_FULL,
                 dest_ip: r_item.sender_ip, dest_port: r_item.sender_port,
                 own_sid: r_item.own_sid, peer_sid: r_item.peer_sid,
                 local_ip: r_item.local_ip, local_port: r_item.local_port,
                 fwd_port: r_item.fwd_port, peer_ip: r_item.peer_ip_in,
                 peer_port: r_item.peer_port_in, last: 1'b1};
        info = '{reply_kind: KIND_INFO,
                 dest_ip: r_item.sender_ip, dest_port: r_item.sender_port,
                 own_sid: r_item.own_sid, peer_sid: r_item.peer_sid,
                 local_ip: r_item.local_ip, local_port: r_item.local_port,
                 fwd_port: f_port, peer_ip: a_ip, peer_port: a_port, last: 1'b0};
        notice = '{reply_kind: KIND_NOTICE,
                 dest_ip: r_peer.mapped_ip, dest_port: r_peer.mapped_port,
                 own_sid: r_item.peer_sid, peer_sid: r_item.own_sid,
                 local_ip: r_item.local_ip, local_port: r_item.local_port,
                 fwd_port: f_port, peer_ip: n_ip, peer_port: n_port, last: 1'b1};
    end

    // memory write: clearing pass, registration, leave
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        case (r_state)
            ST_CLEAR: mem_we = 1'b1;
            ST_DECIDE: begin
                if (out_free && r_item.op == OP_REG && (r_own_hit || r_free_hit)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_own_hit ? r_own_idx : r_free_idx;
                    mem_wdata = '{valid: 1'b1, sid: r_item.own_sid,
                                  mapped_ip: r_item.sender_ip,
                                  mapped_port: r_item.sender_port,
                                  lan_ip: r_item.local_ip,
                                  lan_port: r_item.local_port,
                                  fwd_port: r_item.fwd_port};
                end else if (out_free && r_item.op == OP_LEAVE && r_own_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_own_idx;
                end
            end
            default: mem_we = 1'b0;
        endcase
    end

    // entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd     <= mem[r_idx];
        r_rd_idx <= r_idx;
        r_rd_last <= (r_idx == LAST);
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_SCAN) && r_issuing;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_issuing <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST) begin
                        r_idx   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_item     <= i_item;
                        r_own_hit  <= 1'b0;
                        r_peer_hit <= 1'b0;
                        r_free_hit <= 1'b0;
                        r_idx      <= '0;
                        r_issuing  <= 1'b1;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_issuing) begin
                        if (r_idx == LAST) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    // compare one entry per cycle, first match wins
                    if (r_rd_vld) begin
                        if (!r_own_hit && r_rd.valid && r_rd.sid == r_item.own_sid) begin
                            r_own_hit <= 1'b1;
                            r_own_idx <= r_rd_idx;
                            r_own     <= r_rd;
                        end
                        if (!r_peer_hit && r_rd.valid && r_rd.sid == r_item.peer_sid) begin
                            r_peer_hit <= 1'b1;
                            r_peer     <= r_rd;
                        end
                        if (!r_free_hit && !r_rd.valid) begin
                            r_free_hit <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                        if (r_rd_last) begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    if (out_free) begin
                        r_idx   <= '0;
                        r_state <= ST_IDLE;
                        case (r_item.op)
                            OP_REG: begin
                                r_o       <= echo;
                                r_o_valid <= 1'b1;
                            end
                            OP_QUERY: begin
                                if (r_peer_hit) begin
                                    r_o       <= info;
                                    r_o_valid <= 1'b1;
                                    r_state   <= ST_NOTICE;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_NOTICE: begin
                    if (out_free) begin
                        r_o       <= notice;
                        r_o_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/nat_rendezvous_table_core.sv */
// Rendezvous table for UDP hole punching. The table sits in an entry memory
// with a registered read that is scanned one entry per cycle for the sender,
// the peer and the first free slot. The engine takes an item only in its idle
// state, then scans every entry and decides: a register sends one reply (ack
// or table full), a leave or a query for an unknown peer sends none, and a
// query for a known peer sends client info and then a notice. A stalled reply
// holds the engine in its decide or notice state. After reset a clearing pass
// clears every entry with o_ready low. Lifesign and unknown commands are taken
// and dropped at once while the queue has room. A two-item queue lets packets
// arrive while a scan runs.
// depends on nrt_pkg, nrt_front, nrt_back
`default_nettype none
module nat_rendezvous_table_core
    import nrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = NRT_TABLE_ENTRIES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_command,
    input  wire  [15:0] i_own_sid,
    input  wire  [15:0] i_peer_sid,
    input  wire  [31:0] i_sender_ip,
    input  wire  [15:0] i_sender_port,
    input  wire  [31:0] i_local_ip,
    input  wire  [15:0] i_local_port,
    input  wire  [15:0] i_fwd_port,
    input  wire  [31:0] i_peer_ip_in,
    input  wire  [15:0] i_peer_port_in,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_reply_kind,
    output logic [31:0] o_dest_ip,
    output logic [15:0] o_dest_port,
    output logic [15:0] o_out_own_sid,
    output logic [15:0] o_out_peer_sid,
    output logic [31:0] o_out_local_ip,
    output logic [15:0] o_out_local_port,
    output logic [15:0] o_out_fwd_port,
    output logic [31:0] o_out_peer_ip,
    output logic [15:0] o_out_peer_port,
    output logic        o_last
);
    logic    init, item_valid, item_ready;
    t_item   item;
    t_result res;

    nrt_front u_front (
        .i_clk, .i_rst_n, .i_hold(init), .i_valid, .o_ready,
        .i_command, .i_own_sid, .i_peer_sid, .i_sender_ip, .i_sender_port,
        .i_local_ip, .i_local_port, .i_fwd_port, .i_peer_ip_in, .i_peer_port_in,
        .o_item_valid(item_valid), .o_item(item), .i_item_ready(item_ready)
    );

    nrt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .o_init(init),
        .i_item_valid(item_valid), .i_item(item), .o_item_ready(item_ready),
        .o_valid, .i_ready, .o_result(res)
    );

    // unpack the reply packet onto the ports
    assign o_reply_kind     = res.reply_kind;
    assign o_dest_ip        = res.dest_ip;
    assign o_dest_port      = res.dest_port;
    assign o_out_own_sid    = res.own_sid;
    assign o_out_peer_sid   = res.peer_sid;
    assign o_out_local_ip   = res.local_ip;
    assign o_out_local_port = res.local_port;
    assign o_out_fwd_port   = res.fwd_port;
    assign o_out_peer_ip    = res.peer_ip;
    assign o_out_peer_port  = res.peer_port;
    assign o_last           = res.last;
endmodule
`default_nettype wire

/* src/nrt_checker.sv */
// nrt_checker: port-level assertions for nat_rendezvous_table_core
// bound to the top level below; depends on nrt_pkg
`default_nettype none
module nrt_checker
    import nrt_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_ready,
    input wire [1:0]  o_reply_kind,
    input wire [15:0] o_out_own_sid,
    input wire        o_last
);
    // no reply comes out of reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("reply valid right after reset");

    // a stalled reply holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_reply_kind)
            && $stable(o_out_own_sid) && $stable(o_last))
        else $error("stalled reply changed");

    // client info is not marked last, as a notice of the same query follows it
    a_info_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reply_kind == KIND_INFO |-> !o_last)
        else $error("client info marked last");

    a_others_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reply_kind != KIND_INFO |-> o_last)
        else $error("single reply not marked last");
endmodule

bind nat_rendezvous_table_core nrt_checker u_nrt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_reply_kind(o_reply_kind), .o_out_own_sid(o_out_own_sid), .o_last(o_last)
);
`default_nettype wire

/* tb/sv/testbench.sv */
// testbench for nat_rendezvous_table_core: directed and random packet streams
// checked against an in-bench model of the rendezvous table
// depends on nrt_pkg and the core rtl
`timescale 1ns / 1ps
module testbench;
    import nrt_pkg::*;

    localparam int          SLOTS        = NRT_TABLE_ENTRIES;
    localparam logic [2:0]  CMD_LIFESIGN = 3'd1;
    localparam logic [2:0]  CMD_UNKNOWN  = 3'd4;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 4 * SLOTS + 50;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] own;
        logic [15:0] peer;
        logic [31:0] sip;
        logic [15:0] sport;
        logic [31:0] lip;
        logic [15:0] lport;
        logic [15:0] fport;
        logic [31:0] pip;
        logic [15:0] pport;
    } t_pkt;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_command = '0;
    logic [15:0] i_own_sid = '0;
    logic [15:0] i_peer_sid = '0;
    logic [31:0] i_sender_ip = '0;
    logic [15:0] i_sender_port = '0;
    logic [31:0] i_local_ip = '0;
    logic [15:0] i_local_port = '0;
    logic [15:0] i_fwd_port = '0;
    logic [31:0] i_peer_ip_in = '0;
    logic [15:0] i_peer_port_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_reply_kind;
    logic [31:0] o_dest_ip;
    logic [15:0] o_dest_port;
    logic [15:0] o_out_own_sid;
    logic [15:0] o_out_peer_sid;
    logic [31:0] o_out_local_ip;
    logic [15:0] o_out_local_port;
    logic [15:0] o_out_fwd_port;
    logic [31:0] o_out_peer_ip;
    logic [15:0] o_out_peer_port;
    logic        o_last;

    nat_rendezvous_table_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_command(i_command), .i_own_sid(i_own_sid), .i_peer_sid(i_peer_sid),
        .i_sender_ip(i_sender_ip), .i_sender_port(i_sender_port),
        .i_local_ip(i_local_ip), .i_local_port(i_local_port),
        .i_fwd_port(i_fwd_port), .i_peer_ip_in(i_peer_ip_in),
        .i_peer_port_in(i_peer_port_in),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_reply_kind(o_reply_kind), .o_dest_ip(o_dest_ip), .o_dest_port(o_dest_port),
        .o_out_own_sid(o_out_own_sid), .o_out_peer_sid(o_out_peer_sid),
        .o_out_local_ip(o_out_local_ip), .o_out_local_port(o_out_local_port),
        .o_out_fwd_port(o_out_fwd_port), .o_out_peer_ip(o_out_peer_ip),
        .o_out_peer_port(o_out_peer_port), .o_last(o_last)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // model of the session table
    logic        tbl_valid [SLOTS];
    logic [15:0] tbl_sid   [SLOTS];
    logic [31:0] tbl_mip   [SLOTS];
    logic [15:0] tbl_mport [SLOTS];
    logic [31:0] tbl_lip   [SLOTS];
    logic [15:0] tbl_lport [SLOTS];
    logic [15:0] tbl_fport [SLOTS];

    t_result pending_replies [$];
    int      n_sent = 0;
    int      n_replies = 0;
    int      n_mismatch = 0;
    int      n_full = 0;
    int      n_same_nat = 0;
    int      burst_left = 0;
    int      hold_requests = 0;
    int      hold_served = 0;
    int      hold_left = 0;
    int      rx_cycle = 0;

    function automatic int lookup_sid(logic [15:0] sid);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && tbl_sid[i] == sid) return i;
        return -1;
    endfunction

    function automatic t_result make_reply(logic [1:0] kind, logic [31:0] dip,
            logic [15:0] dport, logic [15:0] osid, logic [15:0] psid, logic [31:0] lip,
            logic [15:0] lport, logic [15:0] fport, logic [31:0] pip, logic [15:0] pport,
            logic last);
        t_result r;
        r.reply_kind = kind; r.dest_ip = dip; r.dest_port = dport;
        r.own_sid = osid; r.peer_sid = psid; r.local_ip = lip;
        r.local_port = lport; r.fwd_port = fport; r.peer_ip = pip;
        r.peer_port = pport; r.last = last;
        return r;
    endfunction

    // update the table model and queue the replies a packet causes
    task automatic predict_replies(t_pkt p);
        int s, r;
        logic same;
        logic [15:0] f, aport, nport;
        logic [31:0] aip, nip;
        case (p.cmd)
            CMD_REGISTER: begin
                s = lookup_sid(p.own);
                if (s < 0)
                    for (int i = 0; i < SLOTS; i++)
                        if (!tbl_valid[i]) begin
                            s = i;
                            break;
                        end
                if (s < 0) begin
                    n_full++;
                    pending_replies.push_back(make_reply(KIND_FULL, p.sip, p.sport,
                        p.own, p.peer, p.lip, p.lport, p.fport, p.pip, p.pport, 1'b1));
                end else begin
                    tbl_valid[s] = 1'b1; tbl_sid[s] = p.own;
                    tbl_mip[s] = p.sip; tbl_mport[s] = p.sport;
                    tbl_lip[s] = p.lip; tbl_lport[s] = p.lport; tbl_fport[s] = p.fport;
                    pending_replies.push_back(make_reply(KIND_ACK, p.sip, p.sport,
                        p.own, p.peer, p.lip, p.lport, p.fport, p.pip, p.pport, 1'b1));
                end
            end
            CMD_QUERY: begin
                s = lookup_sid(p.peer);
                if (s >= 0) begin
                    same = (tbl_mip[s] == p.sip);
                    if (same) begin
                        n_same_nat++;
                        f = p.fport; aip = tbl_lip[s]; aport = tbl_lport[s];
                        nip = aip; nport = aport;
                        r = lookup_sid(p.own);
                        if (r >= 0) begin
                            nip = tbl_lip[r];
                            nport = tbl_lport[r];
                        end
                    end else begin
                        f = tbl_fport[s]; aip = tbl_mip[s]; aport = tbl_mport[s];
                        nip = p.sip; nport = p.sport;
                    end
                    pending_replies.push_back(make_reply(KIND_INFO, p.sip, p.sport,
                        p.own, p.peer, p.lip, p.lport, f, aip, aport, 1'b0));
                    pending_replies.push_back(make_reply(KIND_NOTICE, tbl_mip[s],
                        tbl_mport[s], p.peer, p.own, p.lip, p.lport, f, nip, nport, 1'b1));
                end
            end
            CMD_LEAVE: begin
                s = lookup_sid(p.own);
                if (s >= 0) tbl_valid[s] = 1'b0;
            end
            default: ;
        endcase
    endtask

    // drive one packet, wait for its transfer, then pace the sender in bursts
    task automatic send_packet(t_pkt p);
        i_valid <= 1'b1;
        i_command <= p.cmd; i_own_sid <= p.own; i_peer_sid <= p.peer;
        i_sender_ip <= p.sip; i_sender_port <= p.sport;
        i_local_ip <= p.lip; i_local_port <= p.lport; i_fwd_port <= p.fport;
        i_peer_ip_in <= p.pip; i_peer_port_in <= p.pport;
        do @(posedge i_clk); while (!o_ready);
        predict_replies(p);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    function automatic t_pkt rand_pkt(logic [2:0] cmd);
        t_pkt p;
        p.cmd = cmd;
        p.own = 16'($urandom); p.peer = 16'($urandom);
        p.sip = $urandom; p.sport = 16'($urandom);
        p.lip = $urandom; p.lport = 16'($urandom); p.fport = 16'($urandom);
        p.pip = $urandom; p.pport = 16'($urandom);
        return p;
    endfunction

    // receiver: checks each transfer, stalls on a rotating pattern
    always @(posedge i_clk) begin
        t_result got, want;
        rx_cycle++;
        if (o_valid && i_ready) begin
            got = make_reply(o_reply_kind, o_dest_ip, o_dest_port, o_out_own_sid,
                o_out_peer_sid, o_out_local_ip, o_out_local_port, o_out_fwd_port,
                o_out_peer_ip, o_out_peer_port, o_last);
            n_replies++;
            if (pending_replies.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected reply: %p", got);
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("reply mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
        if (hold_left == 0 && hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 300) % 3)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 99) < 60);
                default: i_ready <= (rx_cycle % 7) < 3;
            endcase
        end
    end

    // extremes, every command and each lookup case
    task automatic test_directed();
        t_pkt p;
        p = rand_pkt(CMD_REGISTER);
        p.own = 16'h0000; p.sip = 32'h0A000001; p.lip = '0; p.lport = '0;
        p.fport = '0; p.pip = '0; p.pport = '0; p.sport = '0; p.peer = '0;
        send_packet(p);
        p = rand_pkt(CMD_REGISTER);
        p.own = 16'hFFFF; p.sip = 32'hFFFFFFFF; p.sport = 16'hFFFF; p.lip = 32'hFFFFFFFF;
        p.lport = 16'hFFFF; p.fport = 16'hFFFF; p.pip = 32'hFFFFFFFF;
        p.pport = 16'hFFFF; p.peer = 16'hFFFF;
        send_packet(p);
        // re-register replaces the old entry
        p = rand_pkt(CMD_REGISTER); p.own = 16'h0000; p.sip = 32'h0A000001;
        send_packet(p);
        p = rand_pkt(CMD_REGISTER); p.own = 16'h1234; p.sip = 32'h0A000001;
        send_packet(p);
        // same nat, requester registered
        p = rand_pkt(CMD_QUERY); p.own = 16'h1234; p.peer = 16'h0000; p.sip = 32'h0A000001;
        send_packet(p);
        // same nat, requester not registered
        p = rand_pkt(CMD_QUERY); p.own = 16'h7777; p.peer = 16'h0000; p.sip = 32'h0A000001;
        send_packet(p);
        // different nat
        p = rand_pkt(CMD_QUERY); p.own = 16'h1234; p.peer = 16'hFFFF; p.sip = 32'h0B000002;
        send_packet(p);
        // unknown peer
        p = rand_pkt(CMD_QUERY); p.peer = 16'h5555;
        send_packet(p);
        send_packet(rand_pkt(CMD_LIFESIGN));
        for (int c = int'(CMD_UNKNOWN); c < 8; c++) send_packet(rand_pkt(3'(c)));
        p = rand_pkt(CMD_LEAVE); p.own = 16'h5555;
        send_packet(p);
        p = rand_pkt(CMD_LEAVE); p.own = 16'h0000;
        send_packet(p);
        p = rand_pkt(CMD_QUERY); p.peer = 16'h0000;
        send_packet(p);
    endtask

    // fill every slot, then hit the full case, replace and free a slot
    task automatic test_table_full();
        t_pkt p;
        for (int k = 0; k < SLOTS + 2; k++) begin
            p = rand_pkt(CMD_REGISTER); p.own = 16'h8000 + 16'(k);
            send_packet(p);
        end
        p = rand_pkt(CMD_REGISTER); p.own = 16'h8003;
        send_packet(p);
        p = rand_pkt(CMD_LEAVE); p.own = 16'h8005;
        send_packet(p);
        p = rand_pkt(CMD_REGISTER); p.own = 16'h9999;
        send_packet(p);
        p = rand_pkt(CMD_REGISTER); p.own = 16'h999A;
        send_packet(p);
        for (int k = 0; k < SLOTS + 4; k++) begin
            p = rand_pkt(CMD_LEAVE); p.own = 16'h8000 + 16'(k);
            send_packet(p);
        end
    endtask

    // random traffic over a small pool of sessions and nat addresses
    task automatic test_random(int count);
        t_pkt p;
        int w;
        logic [31:0] nat_ip [6];
        for (int i = 0; i < 6; i++) nat_ip[i] = $urandom;
        nat_ip[0] = 32'h00000000; nat_ip[1] = 32'hFFFFFFFF;
        for (int n = 0; n < count; n++) begin
            w = $urandom_range(0, 99);
            if (w < 36) p = rand_pkt(CMD_REGISTER);
            else if (w < 72) p = rand_pkt(CMD_QUERY);
            else if (w < 86) p = rand_pkt(CMD_LEAVE);
            else if (w < 91) p = rand_pkt(CMD_LIFESIGN);
            else p = rand_pkt(3'($urandom_range(int'(CMD_UNKNOWN), 7)));
            if ($urandom_range(0, 99) < 88) begin
                p.own = 16'h4000 + 16'($urandom_range(0, 79));
                p.peer = 16'h4000 + 16'($urandom_range(0, 79));
                p.sip = nat_ip[$urandom_range(0, 5)];
            end
            send_packet(p);
        end
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        t_pkt p;
        hold_requests++;
        for (int n = 0; n < 24; n++) begin
            p = rand_pkt($urandom_range(0, 1) ? CMD_QUERY : CMD_REGISTER);
            p.own = 16'h4000 + 16'($urandom_range(0, 7));
            p.peer = 16'h4000 + 16'($urandom_range(0, 7));
            burst_left = 1;
            send_packet(p);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_random(600);
        test_backpressure();
        test_random(620);
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d packets, checked %0d replies (%0d table full, %0d same nat)",
            n_sent, n_replies, n_full, n_same_nat);
        if (n_mismatch == 0 && pending_replies.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches, %0d replies missing", n_mismatch,
                pending_replies.size());
            $display("testbench: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("timeout with %0d replies outstanding", pending_replies.size());
        $display("testbench: FAIL");
        $finish;
    end
endmodule

/* files.f */
src/nrt_pkg.sv
src/nrt_front.sv
src/nrt_back.sv
src/nat_rendezvous_table_core.sv
src/nrt_checker.sv
tb/sv/testbench.sv
